### rtl/pq_pkg.sv
// shared types and constants of the prompt queue with hold and repeat suppression
`timescale 1ns / 1ps
`default_nettype none
package pq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 8;
	localparam logic [15:0] HOLD_RESET = 16'd1200;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_PROMPT = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} pq_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic [7:0]  prompt_id;
		logic [7:0]  source_id;
		logic [31:0] repeat_gap_ms;
		logic        player_busy;
	} in_beat_t;

	typedef struct packed {
		logic       play_valid;
		logic [7:0] play_prompt;
		logic [7:0] play_source;
		logic       busy_res;
		logic [3:0] fill_level;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic exec;
	} pq_cmd_t;

	typedef struct packed {
		logic out_stall;
	} pq_sts_t;

endpackage
`default_nettype wire

### rtl/pq_ctrl.sv
// controller state machine: accepts a beat, then runs one execute step
`timescale 1ns / 1ps
`default_nettype none
module pq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pq_pkg::pq_sts_t sts,
	output pq_pkg::pq_cmd_t     cmd
);
	import pq_pkg::*;

	pq_state_t state_q;
	pq_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.out_stall) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !sts.out_stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/pq_dp.sv
// datapath: ring memory, timing state, repeat check and output register
`timescale 1ns / 1ps
`default_nettype none
module pq_dp #(
	parameter int unsigned QUEUE_DEPTH = pq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pq_pkg::in_beat_t  in_data,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata,
	input  wire pq_pkg::pq_cmd_t   cmd,
	output pq_pkg::pq_sts_t        sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pq_pkg::out_beat_t      out_data
);
	import pq_pkg::*;

	localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] prompt;
		logic [7:0] source;
	} entry_t;

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;

	in_beat_t        item_s1;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]     cur_q;
	logic [31:0]     hold_q;
	logic [7:0]      lp_q;
	logic [31:0]     lt_q;
	logic [15:0]     hold_time_q;
	out_beat_t       out_q;
	logic            out_valid_q;

	function automatic logic hold_fn(input logic [31:0] h, input logic [31:0] t);
		logic [31:0] d;
		d = h - t;
		return (h != 32'd0) && (d != 32'd0) && !d[31];
	endfunction

	logic             is_tick, is_prompt, is_clear;
	logic             hold_now, hold_cur, pop, drop, push, full;
	logic [31:0]      sum;
	logic [31:0]      elapsed;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W:0]   slot_raw;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] head_next;
	logic [CNT_W-1:0] count_next;
	logic             busy;
	logic [CNT_W+3:0] count_ext;
	out_beat_t        res;

	always_comb begin
		is_tick   = item_s1.req_type == REQ_TICK;
		is_prompt = item_s1.req_type == REQ_PROMPT;
		is_clear  = item_s1.req_type == REQ_CLEAR;
		hold_now  = hold_fn(hold_q, item_s1.now_ms);
		hold_cur  = hold_fn(hold_q, cur_q);
		sum       = item_s1.now_ms + {16'd0, hold_time_q};
		elapsed   = cur_q - lt_q;
		full      = count_q == CNT_W'(QUEUE_DEPTH);
		pop       = is_tick && !item_s1.player_busy && !hold_now && (count_q != '0);
		drop      = (lp_q != 8'd0) && (lp_q == item_s1.prompt_id) && (lt_q != 32'd0)
			&& (elapsed < item_s1.repeat_gap_ms);
		push      = is_prompt && (item_s1.prompt_id != 8'd0) && !drop;
		head_inc  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		slot_raw  = (IDX_W+1)'(head_q) + (IDX_W+1)'(count_q);
		if (slot_raw >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			slot = IDX_W'(slot_raw - (IDX_W+1)'(QUEUE_DEPTH));
		end else begin
			slot = slot_raw[IDX_W-1:0];
		end
		if (full) begin
			slot = head_q;
		end

		head_next  = head_q;
		count_next = count_q;
		if (is_clear) begin
			head_next  = '0;
			count_next = '0;
		end else if (pop) begin
			head_next  = head_inc;
			count_next = count_q - 1'b1;
		end else if (push) begin
			if (full) begin
				head_next = head_inc;
			end else begin
				count_next = count_q + 1'b1;
			end
		end

		if (is_tick) begin
			busy = pop ? ((sum != 32'd0) && (hold_time_q != 16'd0)) : hold_now;
		end else if (is_clear) begin
			busy = 1'b0;
		end else begin
			busy = hold_cur;
		end

		count_ext       = {4'b0000, count_next};
		res.play_valid  = pop;
		res.play_prompt = pop ? rd_q.prompt : 8'd0;
		res.play_source = pop ? rd_q.source : 8'd0;
		res.busy_res    = item_s1.player_busy || busy;
		res.fill_level  = count_ext[3:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[head_q];
		if (cmd.exec && push) begin
			mem[slot] <= '{prompt: item_s1.prompt_id, source: item_s1.source_id};
		end
		if (cmd.load) begin
			item_s1 <= in_data;
		end
		if (cmd.exec) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			hold_q      <= '0;
			lp_q        <= '0;
			lt_q        <= '0;
			hold_time_q <= HOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				hold_time_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				head_q  <= head_next;
				count_q <= count_next;
				if (is_tick) begin
					cur_q <= item_s1.now_ms;
				end
				if (is_clear) begin
					hold_q <= '0;
				end else if (pop) begin
					hold_q <= sum;
					lp_q   <= rd_q.prompt;
					lt_q   <= item_s1.now_ms;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_stall = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule
`default_nettype wire

### rtl/prompt_queue_with_hold_and_dedup_unit.sv
// top level of the prompt queue with hold timer and repeat suppression
`timescale 1ns / 1ps
`default_nettype none
// Voice-prompt scheduler. Each input beat is a tick (new time, may start the
// oldest queued prompt when neither the player nor the hold timer is busy), a
// prompt request (dropped when the code is zero or repeats the last played
// prompt within its minimum gap; a full ring drops its oldest entry) or a
// clear of ring and hold. Every beat yields exactly one result beat. An item
// is accepted in ST_IDLE as the head ring entry is read from the registered-read
// ring memory, then executed in ST_EXEC, which loads the output register.
// The next item is accepted while a result waits to be taken. hold_time_ms
// must be written through cfg_we/cfg_wdata while the block is idle (not enforced).
module prompt_queue_with_hold_and_dedup_unit #(
	parameter int unsigned QUEUE_DEPTH = pq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pq_pkg::in_beat_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pq_pkg::out_beat_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata
);
	import pq_pkg::*;

	pq_cmd_t cmd;
	pq_sts_t sts;

	pq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_play_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.play_valid |-> out_data.play_prompt != 8'd0)
		else $error("played prompt code is zero");

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted beat");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an execute step");

	a_load_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.exec))
		else $error("load and execute in the same cycle");

endmodule
`default_nettype wire
